@@ src/hst_pkg.sv @@
// Package for the Hangul syllable tracker: payload structs, classes, positions, constants.
`default_nettype none
package hst_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned TwWidth = 2;

  // Hangul_Syllable_Type ranges
  localparam logic [CpWidth-1:0] LFirst0  = 21'h01100;
  localparam logic [CpWidth-1:0] LLast0   = 21'h0115F;
  localparam logic [CpWidth-1:0] LFirst1  = 21'h0A960;
  localparam logic [CpWidth-1:0] LLast1   = 21'h0A97C;
  localparam logic [CpWidth-1:0] VFirst0  = 21'h01160;
  localparam logic [CpWidth-1:0] VLast0   = 21'h011A7;
  localparam logic [CpWidth-1:0] VFirst1  = 21'h0D7B0;
  localparam logic [CpWidth-1:0] VLast1   = 21'h0D7C6;
  localparam logic [CpWidth-1:0] TFirst0  = 21'h011A8;
  localparam logic [CpWidth-1:0] TLast0   = 21'h011FF;
  localparam logic [CpWidth-1:0] TFirst1  = 21'h0D7CB;
  localparam logic [CpWidth-1:0] TLast1   = 21'h0D7FB;
  localparam logic [CpWidth-1:0] SFirst   = 21'h0AC00;
  localparam logic [CpWidth-1:0] SLast    = 21'h0D7A3;

  // Syllable offset fits 14 bits; offset/4 fits 12 bits.
  localparam int unsigned OffWidth = 14;
  localparam int unsigned QWidth   = OffWidth - 2;
  // Inverse of 7 modulo 2**12; y is a multiple of 7 iff y*inv mod 2**12 <= (2**12-1)/7.
  localparam logic [QWidth-1:0] Inv7      = 12'd3511;
  localparam logic [QWidth-1:0] Div7Limit = 12'd585;

  localparam logic [TwWidth-1:0] IsolatedWidth = 2'd2;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_L,
    CLS_V,
    CLS_T,
    CLS_LV,
    CLS_LVT
  } cls_e;

  typedef enum logic [1:0] {
    POS_NONE = 2'd0,
    POS_L    = 2'd1,
    POS_V    = 2'd2,
    POS_T    = 2'd3
  } pos_e;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic [TwWidth-1:0] table_width;
  } in_t;

  typedef struct packed {
    logic               continues_syllable;
    logic [TwWidth-1:0] hangul_width;
    logic [1:0]         new_position;
  } out_t;

endpackage
`default_nettype wire

@@ src/hangul_syllable_tracker_top.sv @@
// Top level of the Hangul syllable tracker: input register, classifier, result register.
`default_nettype none
// Hangul syllable tracker.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one code point and
// its width-table width per transfer. Output channel (out_valid_o / out_ready_i /
// out_data_o) returns one result per input: continues_syllable, hangul_width and
// the new syllable position.
// Each input passes the input register, then the result register, before its
// result is offered. Throughput: one item per cycle while the receiver takes
// results, set by the single position register that both the classifier reads
// and the result stage writes in the same cycle.
// Both register stages advance together when the result register is empty or
// is being taken, so a stalled receiver holds the result and the input register
// fills; in_ready_o drops only when both are full and out_ready_i is low.
// Reset (rst_ni low, asynchronous) empties both stages and sets the syllable
// position to none. No configuration registers.
module hangul_syllable_tracker_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire hst_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output hst_pkg::out_t      out_data_o
);
  import hst_pkg::*;

  // Stage 1: input register
  logic s1_valid_q, s1_valid_d;
  in_t  s1_data_q;
  logic s1_adv;

  // Stage 2: result register and syllable position
  logic out_valid_q, out_valid_d;
  out_t out_data_q;
  pos_e pos_q, pos_d;
  logic out_free;

  // Combinational classification of the stage 1 item
  cls_e                cls;
  logic [CpWidth-1:0]  cp;
  logic [15:0]         off_full;
  logic [QWidth-1:0]   quarter;
  logic [QWidth-1:0]   prod;
  logic                div28;
  logic                cont;
  logic [TwWidth-1:0]  width;
  pos_e                next_pos;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  assign cp       = s1_data_q.code_point;
  // offset from the first precomposed syllable; only meaningful inside the range
  assign off_full = cp[15:0] - SFirst[15:0];
  assign quarter  = off_full[OffWidth-1:2];
  assign prod     = quarter * Inv7;
  assign div28    = (off_full[1:0] == 2'b00) && (prod <= Div7Limit);

  always_comb begin
    if ((cp >= LFirst0 && cp <= LLast0) || (cp >= LFirst1 && cp <= LLast1)) begin
      cls = CLS_L;
    end else if ((cp >= VFirst0 && cp <= VLast0) || (cp >= VFirst1 && cp <= VLast1)) begin
      cls = CLS_V;
    end else if ((cp >= TFirst0 && cp <= TLast0) || (cp >= TFirst1 && cp <= TLast1)) begin
      cls = CLS_T;
    end else if (cp >= SFirst && cp <= SLast) begin
      cls = div28 ? CLS_LV : CLS_LVT;
    end else begin
      cls = CLS_NONE;
    end
  end

  // does this character continue the syllable held so far
  always_comb begin
    case (pos_q)
      POS_L:   cont = (cls != CLS_T) && (cls != CLS_NONE);
      POS_V:   cont = (cls == CLS_V) || (cls == CLS_T);
      POS_T:   cont = (cls == CLS_T);
      default: cont = 1'b0;
    endcase
  end

  // width and position update
  always_comb begin
    width    = '0;
    next_pos = pos_q;
    case (cls)
      CLS_LV: begin
        next_pos = POS_V;
        width    = s1_data_q.table_width;
      end
      CLS_LVT: begin
        next_pos = POS_T;
        width    = s1_data_q.table_width;
      end
      CLS_L: begin
        next_pos = POS_L;
        if (pos_q != POS_L) width = s1_data_q.table_width;
      end
      CLS_V: begin
        if (pos_q == POS_L || pos_q == POS_V) begin
          next_pos = POS_V;
        end else begin
          next_pos = POS_NONE;
          width    = IsolatedWidth;
        end
      end
      CLS_T: begin
        if (pos_q == POS_V || pos_q == POS_T) begin
          next_pos = POS_T;
        end else begin
          next_pos = POS_NONE;
          width    = IsolatedWidth;
        end
      end
      default: next_pos = POS_NONE;  // non-Hangul ends the syllable
    endcase
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    if (in_ready_o) s1_valid_d = in_valid_i;
    if (out_free) out_valid_d = s1_valid_q;
    if (s1_adv) pos_d = next_pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= POS_NONE;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) s1_data_q <= in_data_i;
    if (s1_adv) begin
      out_data_q.continues_syllable <= cont;
      out_data_q.hangul_width       <= width;
      out_data_q.new_position       <= next_pos;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // the shown result always carries the position currently held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.new_position == pos_q))
    else $error("result position differs from held position");

  // a continuing character never leaves the syllable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.continues_syllable) |->
      (out_data_o.new_position != POS_NONE))
    else $error("continuing character ended the syllable");

  // a stalled input-register item is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q)
    else $error("stalled item lost from input register");
`endif

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Testbench for the Hangul syllable tracker: directed table, random syllable streams, self-check.
`default_nettype none
module tb;
  import hst_pkg::*;

  // One row of the directed script. When typed is set the row carries its own
  // expected result; otherwise the syllable tracker below supplies it.
  typedef struct packed {
    logic [CpWidth-1:0] cp;
    logic [TwWidth-1:0] tw;
    logic               typed;
    logic               cont;
    logic [TwWidth-1:0] width;
    pos_e               pos;
  } script_row_t;

  localparam int unsigned ScriptLen      = 24;
  localparam int unsigned RandomPerPhase = 410;
  localparam int unsigned TrailingSpan   = 28;   // LV every 28 code points
  localparam int unsigned LvCount        = 399;  // LV syllables in the block
  localparam int unsigned DrainLimit     = 5000;
  localparam int unsigned SettleCycles   = 8;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Our copy of the syllable position, advanced on every accepted input transfer.
  pos_e        tracked_pos;
  out_t        pending_results [$];
  int unsigned mismatch_count;
  int unsigned random_sent;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 59;

  // Range edges used to aim noise right around the class boundaries.
  logic [CpWidth-1:0] range_edges [14] = '{
    LFirst0, LLast0, LFirst1, LLast1, VFirst0, VLast0, VFirst1, VLast1,
    TFirst0, TLast0, TFirst1, TLast1, SFirst, SLast
  };

  // Directed script: extremes, every class from several positions, table width three,
  // unassigned gaps inside the Hangul blocks, values past the Unicode range.
  script_row_t script [ScriptLen] = '{
    // nothing Hangul right after reset
    {21'h00000, 2'd0, 1'b1, 1'b0, 2'd0, POS_NONE},
    {21'h1FFFFF, 2'd3, 1'b1, 1'b0, 2'd0, POS_NONE},  // all ones, beyond Unicode
    {21'h10FFFF, 2'd2, 1'b1, 1'b0, 2'd0, POS_NONE},  // last scalar value
    // lone vowel and trailing jamo with no syllable open
    {21'h01160, 2'd1, 1'b1, 1'b0, IsolatedWidth, POS_NONE},
    {21'h011A8, 2'd0, 1'b1, 1'b0, IsolatedWidth, POS_NONE},
    // L starts a syllable and takes the table width
    {21'h01100, 2'd2, 1'b1, 1'b0, 2'd2, POS_L},
    {21'h0115F, 2'd1, 1'b0, 1'b0, 2'd0, POS_NONE},   // L conjoins with L
    {21'h011A7, 2'd3, 1'b0, 1'b0, 2'd0, POS_NONE},   // V after L
    {21'h0D7B0, 2'd2, 1'b0, 1'b0, 2'd0, POS_NONE},   // V after V
    {21'h011FF, 2'd1, 1'b0, 1'b0, 2'd0, POS_NONE},   // T after V
    {21'h0D7FB, 2'd0, 1'b0, 1'b0, 2'd0, POS_NONE},   // T after T
    {21'h0D7C6, 2'd3, 1'b0, 1'b0, 2'd0, POS_NONE},   // V after T: isolated
    {21'h0A960, 2'd3, 1'b0, 1'b0, 2'd0, POS_NONE},   // L start, width three
    {21'h0D7CB, 2'd2, 1'b0, 1'b0, 2'd0, POS_NONE},   // T after L: isolated
    {21'h0AC00, 2'd2, 1'b0, 1'b0, 2'd0, POS_NONE},   // first LV
    {21'h0AC01, 2'd1, 1'b0, 1'b0, 2'd0, POS_NONE},   // LVT after V
    {21'h0D7A3, 2'd3, 1'b0, 1'b0, 2'd0, POS_NONE},   // last LVT, width three
    {21'h0A97C, 2'd0, 1'b0, 1'b0, 2'd0, POS_NONE},   // last L after T
    {21'h0AC1C, 2'd1, 1'b0, 1'b0, 2'd0, POS_NONE},   // LV after L
    // gaps inside the Hangul blocks end the syllable
    {21'h0D7A4, 2'd2, 1'b1, 1'b0, 2'd0, POS_NONE},
    {21'h01100, 2'd1, 1'b0, 1'b0, 2'd0, POS_NONE},
    {21'h0D7C7, 2'd1, 1'b1, 1'b0, 2'd0, POS_NONE},
    {21'h0AC00, 2'd0, 1'b0, 1'b0, 2'd0, POS_NONE},
    {21'h0D7FC, 2'd2, 1'b1, 1'b0, 2'd0, POS_NONE}
  };

  hangul_syllable_tracker_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Hangul_Syllable_Type of a code point.
  function automatic cls_e syllable_class(logic [CpWidth-1:0] cp);
    if ((cp >= LFirst0 && cp <= LLast0) || (cp >= LFirst1 && cp <= LLast1))
      return CLS_L;
    if ((cp >= VFirst0 && cp <= VLast0) || (cp >= VFirst1 && cp <= VLast1))
      return CLS_V;
    if ((cp >= TFirst0 && cp <= TLast0) || (cp >= TFirst1 && cp <= TLast1))
      return CLS_T;
    if (cp >= SFirst && cp <= SLast)
      return ((cp - SFirst) % TrailingSpan == 0) ? CLS_LV : CLS_LVT;
    return CLS_NONE;
  endfunction

  // Result of one character given the tracked position; advances the position.
  function automatic out_t track_syllable(in_t ch);
    cls_e cls;
    pos_e nxt;
    out_t res;
    cls = syllable_class(ch.code_point);
    res = '0;
    case (tracked_pos)
      POS_L: res.continues_syllable = (cls != CLS_T && cls != CLS_NONE);
      POS_V: res.continues_syllable = (cls == CLS_V || cls == CLS_T);
      POS_T: res.continues_syllable = (cls == CLS_T);
      default: res.continues_syllable = 1'b0;
    endcase
    nxt = tracked_pos;
    case (cls)
      CLS_NONE: nxt = POS_NONE;
      CLS_LV: begin
        nxt = POS_V;
        res.hangul_width = ch.table_width;
      end
      CLS_LVT: begin
        nxt = POS_T;
        res.hangul_width = ch.table_width;
      end
      CLS_L: begin
        if (tracked_pos != POS_L) res.hangul_width = ch.table_width;
        nxt = POS_L;
      end
      CLS_V: begin
        if (tracked_pos == POS_L || tracked_pos == POS_V) begin
          nxt = POS_V;
        end else begin
          nxt = POS_NONE;
          res.hangul_width = IsolatedWidth;
        end
      end
      default: begin
        if (tracked_pos == POS_V || tracked_pos == POS_T) begin
          nxt = POS_T;
        end else begin
          nxt = POS_NONE;
          res.hangul_width = IsolatedWidth;
        end
      end
    endcase
    tracked_pos = nxt;
    res.new_position = nxt;
    return res;
  endfunction

  function automatic logic [CpWidth-1:0] pick_in_range(logic [CpWidth-1:0] lo,
                                                      logic [CpWidth-1:0] hi);
    return CpWidth'(lo + $urandom_range(0, hi - lo));
  endfunction

  // Random code point of the given class; class none gives noise of three kinds.
  function automatic logic [CpWidth-1:0] pick_code_point(cls_e cls);
    logic [CpWidth-1:0] cp;
    case (cls)
      CLS_L: cp = $urandom_range(0, 1) ? pick_in_range(LFirst0, LLast0)
                                        : pick_in_range(LFirst1, LLast1);
      CLS_V: cp = $urandom_range(0, 1) ? pick_in_range(VFirst0, VLast0)
                                        : pick_in_range(VFirst1, VLast1);
      CLS_T: cp = $urandom_range(0, 1) ? pick_in_range(TFirst0, TLast0)
                                        : pick_in_range(TFirst1, TLast1);
      CLS_LV: cp = CpWidth'(SFirst + TrailingSpan * $urandom_range(0, LvCount - 1));
      CLS_LVT: cp = CpWidth'(SFirst + TrailingSpan * $urandom_range(0, LvCount - 1)
                             + $urandom_range(1, TrailingSpan - 1));
      default: begin
        case ($urandom_range(0, 2))
          0: cp = CpWidth'($urandom());
          1: cp = CpWidth'($urandom_range(0, 16'hFFFF));
          default: cp = CpWidth'(range_edges[$urandom_range(0, 13)] - 2
                                 + $urandom_range(0, 4));
        endcase
      end
    endcase
    return cp;
  endfunction

  // Offer one character and hold it until the transfer; the expectation is
  // queued at the accepting edge. Returns at the following falling edge with
  // valid still high, so a back-to-back item never toggles it.
  task automatic send_char(in_t ch, logic typed, out_t typed_res);
    out_t model_res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= ch;
    do @(posedge clk_i); while (!in_ready);
    model_res = track_syllable(ch);
    pending_results.push_back(typed ? typed_res : model_res);
    @(negedge clk_i);
  endtask

  task automatic send_class(cls_e cls);
    in_t ch;
    ch.code_point  = pick_code_point(cls);
    ch.table_width = TwWidth'($urandom_range(0, 3));
    send_char(ch, 1'b0, '0);
    random_sent++;
  endtask

  // Mostly well-formed syllables with random jamo, the rest out-of-order
  // classes and non-Hangul noise.
  task automatic send_random_run();
    int unsigned shape;
    shape = $urandom_range(0, 99);
    if (shape < 35) begin
      repeat ($urandom_range(1, 2)) send_class(CLS_L);
      repeat ($urandom_range(1, 2)) send_class(CLS_V);
      repeat ($urandom_range(0, 2)) send_class(CLS_T);
    end else if (shape < 50) begin
      send_class(CLS_LV);
      repeat ($urandom_range(0, 2)) send_class(CLS_T);
    end else if (shape < 60) begin
      send_class(CLS_LVT);
      repeat ($urandom_range(0, 1)) send_class(CLS_T);
    end else if (shape < 75) begin
      send_class(cls_e'($urandom_range(1, 5)));
    end else begin
      send_class(CLS_NONE);
    end
  endtask

  task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: ready changes only at the falling edge.
  always @(negedge clk_i) begin
    out_ready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every result transfer is checked against the oldest pending expectation.
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni === 1'b1 && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h, nothing pending", $time, out_data);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("continues_syllable", {1'b0, want.continues_syllable},
                    {1'b0, out_data.continues_syllable});
        check_field("hangul_width", want.hangul_width, out_data.hangul_width);
        check_field("new_position", want.new_position, out_data.new_position);
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned drain;
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    tracked_pos    = POS_NONE;
    mismatch_count = 0;
    random_sent    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < ScriptLen; i++) begin
      send_char({script[i].cp, script[i].tw}, script[i].typed,
                {script[i].cont, script[i].width, script[i].pos});
    end

    // Phases: sender sparse / receiver stalling, then swapped, then full rate.
    for (phase = 0; phase < 3; phase++) begin
      // sender holds off until the block has returned every result
      in_valid <= 1'b0;
      do @(negedge clk_i); while (pending_results.size() != 0);
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 31 : 0;
      while (random_sent < RandomPerPhase * (phase + 1)) send_random_run();
    end

    in_valid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < DrainLimit) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (SettleCycles) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[hangul_syllable_tracker_top] OK");
    end else begin
      $display("[hangul_syllable_tracker_top] ERROR");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("[hangul_syllable_tracker_top] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
